// File: sv/thlu_pkg.sv
// Package for the temperature compensated humidity lookup.
// Holds sizes, calibration constants, the calibration table and the job type.
// No dependencies.
package thlu_pkg;

   localparam int LEVELS    = 18;
   localparam int TEMP_ROWS = 13;

   localparam int LEVEL_W  = $clog2(LEVELS);
   localparam int ROW_W    = $clog2(TEMP_ROWS);
   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 8;
   localparam int TCLAMP_W = 6;
   localparam int FRAC_W   = 3;
   localparam int HUM_W    = 7;

   localparam int TEMP_STEP   = 5;
   localparam int HUMI_STEP   = 5;
   localparam int HUMI_TOP    = 95;
   localparam int HUMI_BOTTOM = 10;
   localparam int TEMP_HIGH   = 60;
   localparam int TEMP_LOW    = 0;

   // Division by five as a multiply and shift, exact over the ranges used.
   localparam int TEMP_RECIP = 13;
   localparam int TEMP_SHIFT = 6;
   localparam int DIV5_RECIP = 52429;
   localparam int DIV5_SHIFT = 18;

   localparam logic [SAMPLE_W-1:0] CAL_ROM [TEMP_ROWS][LEVELS] = '{
      '{12'd154, 12'd155, 12'd160, 12'd165, 12'd177, 12'd204, 12'd257, 12'd354, 12'd516,
        12'd803, 12'd1189, 12'd1633, 12'd2101, 12'd2579, 12'd2919, 12'd3204, 12'd3434,
        12'd3595},
      '{12'd154, 12'd155, 12'd161, 12'd168, 12'd186, 12'd223, 12'd296, 12'd429, 12'd650,
        12'd985, 12'd1408, 12'd1874, 12'd2330, 12'd2796, 12'd3113, 12'd3356, 12'd3571,
        12'd3702},
      '{12'd154, 12'd156, 12'd164, 12'd175, 12'd199, 12'd250, 12'd342, 12'd508, 12'd775,
        12'd1154, 12'd1633, 12'd2127, 12'd2540, 12'd2945, 12'd3236, 12'd3456, 12'd3619,
        12'd3736},
      '{12'd154, 12'd157, 12'd168, 12'd183, 12'd217, 12'd284, 12'd410, 12'd619, 12'd941,
        12'd1367, 12'd1835, 12'd2330, 12'd2750, 12'd3113, 12'd3370, 12'd3555, 12'd3676,
        12'd3780},
      '{12'd155, 12'd158, 12'd176, 12'd197, 12'd237, 12'd320, 12'd477, 12'd750, 12'd1121,
        12'd1604, 12'd2075, 12'd2540, 12'd2919, 12'd3236, 12'd3442, 12'd3611, 12'd3736,
        12'd3825},
      '{12'd155, 12'd160, 12'd183, 12'd210, 12'd264, 12'd375, 12'd579, 12'd901, 12'd1338,
        12'd1855, 12'd2298, 12'd2727, 12'd3055, 12'd3342, 12'd3539, 12'd3676, 12'd3780,
        12'd3853},
      '{12'd155, 12'd161, 12'd191, 12'd230, 12'd301, 12'd451, 12'd696, 12'd1062, 12'd1537,
        12'd2075, 12'd2502, 12'd2894, 12'd3204, 12'd3427, 12'd3595, 12'd3719, 12'd3807,
        12'd3871},
      '{12'd156, 12'd164, 12'd202, 12'd250, 12'd344, 12'd508, 12'd803, 12'd1226, 12'd1728,
        12'd2238, 12'd2705, 12'd3055, 12'd3302, 12'd3501, 12'd3652, 12'd3754, 12'd3834,
        12'd3899},
      '{12'd156, 12'd166, 12'd214, 12'd284, 12'd397, 12'd619, 12'd985, 12'd1429, 12'd1936,
        12'd2430, 12'd2820, 12'd3143, 12'd3370, 12'd3547, 12'd3685, 12'd3780, 12'd3853,
        12'd3909},
      '{12'd157, 12'd171, 12'd237, 12'd315, 12'd477, 12'd750, 12'd1154, 12'd1604, 12'd2101,
        12'd2540, 12'd2945, 12'd3236, 12'd3442, 12'd3603, 12'd3728, 12'd3816, 12'd3871,
        12'd3918},
      '{12'd158, 12'd174, 12'd253, 12'd354, 12'd545, 12'd865, 12'd1328, 12'd1835, 12'd2298,
        12'd2727, 12'd3055, 12'd3329, 12'd3516, 12'd3660, 12'd3762, 12'd3843, 12'd3895,
        12'd3938},
      '{12'd159, 12'd179, 12'd278, 12'd401, 12'd634, 12'd941, 12'd1524, 12'd2027, 12'd2502,
        12'd2844, 12'd3173, 12'd3398, 12'd3563, 12'd3693, 12'd3789, 12'd3862, 12'd3909,
        12'd3947},
      '{12'd160, 12'd184, 12'd301, 12'd457, 12'd739, 12'd1035, 12'd1711, 12'd2209, 12'd2662,
        12'd2999, 12'd3275, 12'd3456, 12'd3611, 12'd3728, 12'd3807, 12'd3871, 12'd3918,
        12'd3957}
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [ROW_W-1:0]    lo;
      logic [ROW_W-1:0]    hi;
      logic [FRAC_W-1:0]   frac;
   } thlu_job_type;

endpackage

// File: sv/thlu_front.sv
// Front end: accepts an item, clamps the temperature and picks the two table rows.
// Depends on thlu_pkg; feeds thlu_queue.
module thlu_front import thlu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SAMPLE_W-1:0]      adc_sample,
   input  logic signed [TEMP_W-1:0] temperature,
   input  logic                     queue_full,
   output logic                     busy,
   output logic                     push_valid,
   output thlu_job_type             push_job
);

   logic                  valid_ff, valid_in;
   thlu_job_type          job_ff, job_in;
   logic                  accept;
   logic [TCLAMP_W-1:0]   t_clamp;
   logic [9:0]            t_scaled;
   logic [ROW_W-1:0]      lo_raw, lo_row;
   logic [TCLAMP_W-1:0]   lo_times5;

   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;

   always_comb begin
      if (temperature > $signed(TEMP_W'(TEMP_HIGH))) begin
         t_clamp = TCLAMP_W'(TEMP_HIGH);
      end else if (temperature < $signed(TEMP_W'(TEMP_LOW))) begin
         t_clamp = TCLAMP_W'(TEMP_LOW);
      end else begin
         t_clamp = temperature[TCLAMP_W-1:0];
      end
   end

   // t / 5 for t in 0..60 is (t * 13) >> 6.
   assign t_scaled  = 10'(t_clamp) * 10'(TEMP_RECIP);
   assign lo_raw    = ROW_W'(t_scaled >> TEMP_SHIFT);
   assign lo_row    = (lo_raw > ROW_W'(TEMP_ROWS - 1)) ? ROW_W'(TEMP_ROWS - 1) : lo_raw;
   assign lo_times5 = TCLAMP_W'(lo_raw) * TCLAMP_W'(TEMP_STEP);

   always_comb begin
      job_in.sample = adc_sample;
      job_in.lo     = lo_row;
      job_in.hi     = (lo_row == ROW_W'(TEMP_ROWS - 1)) ? lo_row : lo_row + 1'b1;
      job_in.frac   = FRAC_W'(t_clamp - lo_times5);
   end

   assign valid_in = accept || (valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign push_valid = valid_ff && !queue_full;
   assign push_job   = job_ff;

endmodule

// File: sv/thlu_queue.sv
// Two-entry queue between the front end and the lookup engine.
// Depends on thlu_pkg.
module thlu_queue import thlu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  thlu_job_type push_job,
   input  logic         pop,
   output logic         full,
   output logic         pop_valid,
   output thlu_job_type pop_job
);

   thlu_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/thlu_back.sv
// Lookup engine: builds the interpolated row one level at a time, searches it,
// and divides for the fractional humidity step. Depends on thlu_pkg.
module thlu_back import thlu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  thlu_job_type     job,
   output logic             job_pop,
   output logic             rsp_valid,
   output logic [HUM_W-1:0] rsp_humidity,
   output logic             rsp_saturated
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_ROW   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;

   logic [2:0]          state_ff, state_in;
   thlu_job_type        job_ff, job_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [SAMPLE_W-1:0] a_ff, a_in;
   logic signed [15:0]  prod_ff, prod_in;
   logic signed [13:0]  below_ff, below_in;
   logic signed [13:0]  cur_ff, cur_in;
   logic [15:0]         rem_ff, rem_in;
   logic [2:0]          quo_ff, quo_in;
   logic [1:0]          bit_ff, bit_in;
   logic                out_valid_ff, out_valid_in;
   logic [HUM_W-1:0]    out_hum_ff, out_hum_in;
   logic                out_sat_ff, out_sat_in;

   logic [SAMPLE_W-1:0] rom_a, rom_b;
   logic signed [12:0]  diff;
   logic signed [15:0]  diff_ext, frac_ext;
   logic [14:0]         mag;
   logic [30:0]         qprod;
   logic [12:0]         q;
   logic signed [13:0]  q_signed, row_val, sample_s;
   logic [15:0]         gap, num;
   logic signed [13:0]  den;
   logic [15:0]         trial;
   logic [2:0]          quo_next;
   logic [LEVEL_W-1:0]  level_m1;
   logic [7:0]          hum_sum;

   assign rom_a    = CAL_ROM[job_ff.lo][level_ff];
   assign rom_b    = CAL_ROM[job_ff.hi][level_ff];
   assign diff     = $signed({1'b0, rom_b}) - $signed({1'b0, rom_a});
   assign diff_ext = {{3{diff[12]}}, diff};
   assign frac_ext = {13'b0, job_ff.frac};
   assign prod_in  = diff_ext * frac_ext;

   // Truncating division by five works on the magnitude, then restores the sign.
   assign mag      = prod_ff[15] ? 15'(-prod_ff) : prod_ff[14:0];
   assign qprod    = 31'(mag) * 31'(DIV5_RECIP);
   assign q        = qprod[DIV5_SHIFT+12:DIV5_SHIFT];
   assign q_signed = prod_ff[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   assign row_val  = $signed({2'b0, a_ff}) + q_signed;
   assign sample_s = $signed({2'b0, job_ff.sample});

   assign gap      = 16'(sample_s - below_ff);
   assign num      = (gap << 2) + gap;
   assign den      = cur_ff - below_ff;
   assign trial    = 16'(den) << bit_ff;
   assign quo_next = quo_ff | (3'd1 << bit_ff);

   assign level_m1 = level_ff - 1'b1;
   assign hum_sum  = 8'(HUMI_BOTTOM) + 8'(level_m1) * 8'(HUMI_STEP) + 8'(quo_in);

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      level_in     = level_ff;
      a_in         = a_ff;
      below_in     = below_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      out_valid_in = 1'b0;
      out_hum_in   = out_hum_ff;
      out_sat_in   = out_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               level_in = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            a_in     = rom_a;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (sample_s <= row_val) begin
               if (level_ff == '0) begin
                  out_valid_in = 1'b1;
                  out_hum_in   = HUM_W'(HUMI_BOTTOM);
                  out_sat_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  cur_in   = row_val;
                  rem_in   = num;
                  quo_in   = '0;
                  bit_in   = 2'd2;
                  state_in = ST_DIV;
               end
            end else begin
               below_in = row_val;
               if (level_ff == LEVEL_W'(LEVELS - 1)) begin
                  out_valid_in = 1'b1;
                  out_hum_in   = HUM_W'(HUMI_TOP);
                  out_sat_in   = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  level_in = level_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DIV: begin
            // The quotient is at most five, so three restoring steps suffice.
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               quo_in = quo_next;
            end
            if (bit_ff == 2'd0) begin
               out_valid_in = 1'b1;
               out_hum_in   = (hum_sum > 8'(HUMI_TOP)) ? HUM_W'(HUMI_TOP) : hum_sum[HUM_W-1:0];
               out_sat_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff     <= job_in;
      level_ff   <= level_in;
      a_ff       <= a_in;
      prod_ff    <= prod_in;
      below_ff   <= below_in;
      cur_ff     <= cur_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      bit_ff     <= bit_in;
      out_hum_ff <= out_hum_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_humidity  = out_hum_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

// File: sv/temp_compensated_humidity_lookup.sv
// Top level of the temperature compensated humidity lookup.
// Depends on thlu_pkg, thlu_front, thlu_queue and thlu_back.
//
// An item is taken when start is high and busy is low; its humidity comes back
// on rsp_humidity with rsp_saturated for one cycle, marked by rsp_valid, and the
// receiver has to take it then. A sample at or below the first table entry gives
// 10 %RH; one above the top entry gives 95 %RH with rsp_saturated set. The engine
// builds the interpolated table row one level at a time, through a fetch state
// and a row state per level, stops at the first entry at or above the sample,
// then runs a restoring division for the fractional step.
// A two-entry queue lets the front end take up to three items ahead of the engine
// before busy rises.
module temp_compensated_humidity_lookup import thlu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [SAMPLE_W-1:0]      req_adc_sample,
   input  logic signed [TEMP_W-1:0] req_temperature,
   output logic                     rsp_valid,
   output logic [HUM_W-1:0]         rsp_humidity,
   output logic                     rsp_saturated
);

   logic         queue_full;
   logic         push_valid;
   thlu_job_type push_job;
   logic         job_pop;
   logic         job_valid;
   thlu_job_type job;

   thlu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .adc_sample  (req_adc_sample),
      .temperature (req_temperature),
      .queue_full  (queue_full),
      .busy        (busy),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   thlu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (queue_full),
      .pop_valid (job_valid),
      .pop_job   (job)
   );

   thlu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .rsp_valid     (rsp_valid),
      .rsp_humidity  (rsp_humidity),
      .rsp_saturated (rsp_saturated)
   );

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_saturated_top : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_humidity == HUM_W'(HUMI_TOP)))
      else $error("saturated result without top humidity");

   a_humidity_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity >= HUM_W'(HUMI_BOTTOM) && rsp_humidity <= HUM_W'(HUMI_TOP)))
      else $error("humidity out of range");

   a_accept_staged : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (push_valid || queue_full))
      else $error("accepted item not held in the front end");

endmodule
